>>> rtl/ycc_pkg.sv
// Shared constants and types for the YCbCr 4:1:1 group to RGB converter.
`default_nettype none

package ycc_pkg;

	localparam int LUMA_W   = 8;
	localparam int CHROMA_W = 8;
	localparam int LANES    = 4;
	localparam int OFF_W    = 9;

	localparam int RB_NUM_W  = 19;
	localparam int RED_COEF  = 1402;
	localparam int BLUE_COEF = 1772;
	localparam int RB_HALF   = 500;
	localparam int RB_DIV    = 1000;
	localparam int RB_SHIFT  = 24;
	localparam int RB_RECIP  = (1 << RB_SHIFT) / RB_DIV;

	localparam int G_NUM_W     = 25;
	localparam int G_CB_COEF   = 34414;
	localparam int G_CR_COEF   = 71414;
	localparam int G_HALF      = 50000;
	localparam int G_DIV       = 100000;
	localparam int G_SHIFT     = 30;
	localparam int G_RECIP     = (1 << G_SHIFT) / G_DIV;

	typedef struct packed {
		logic s2;
		logic s3;
	} ycc_adv_t;

	typedef struct packed {
		logic [LUMA_W-1:0] red;
		logic [LUMA_W-1:0] green;
		logic [LUMA_W-1:0] blue;
	} ycc_pixel_t;

endpackage

`default_nettype wire

>>> rtl/ycc_cdiv.sv
// Two-stage signed division by a constant, truncating toward zero.
`default_nettype none

module ycc_cdiv
	import ycc_pkg::*;
#(
	parameter int NUM_W   = RB_NUM_W,
	parameter int QUO_W   = OFF_W,
	parameter int DIVISOR = RB_DIV,
	parameter int SHIFT   = RB_SHIFT,
	parameter int RECIP   = RB_RECIP
) (
	input  wire logic                    clk,
	input  wire ycc_adv_t                adv,
	input  wire logic signed [NUM_W-1:0] num,
	output logic signed [QUO_W-1:0]      quo
);

	localparam int RCP_W  = $clog2(RECIP + 1);
	localparam int PROD_W = NUM_W + RCP_W;
	localparam int QM_W   = QUO_W - 1;

	logic              neg;
	logic [NUM_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [QM_W-1:0]   q0;

	logic              neg_s2;
	logic [NUM_W-1:0]  mag_s2;
	logic [QM_W-1:0]   q0_s2;

	logic [NUM_W-1:0]        back;
	logic [NUM_W-1:0]        rem;
	logic [QM_W-1:0]         qmag;
	logic signed [QUO_W-1:0] qpos;
	logic signed [QUO_W-1:0] quo_s3;

	always_comb begin
		neg  = num[NUM_W-1];
		mag  = neg ? NUM_W'(-num) : NUM_W'(num);
		prod = PROD_W'(mag) * PROD_W'(RECIP);
		q0   = QM_W'(prod >> SHIFT);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			neg_s2 <= neg;
			mag_s2 <= mag;
			q0_s2  <= q0;
		end
	end

	// estimate is low by at most one: correct with a single compare
	always_comb begin
		back = NUM_W'(NUM_W'(q0_s2) * NUM_W'(DIVISOR));
		rem  = mag_s2 - back;
		qmag = q0_s2 + QM_W'(rem >= NUM_W'(DIVISOR));
		qpos = signed'({1'b0, qmag});
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			quo_s3 <= neg_s2 ? -qpos : qpos;
		end
	end

	assign quo = quo_s3;

endmodule

`default_nettype wire

>>> rtl/ycc_lane.sv
// One pixel lane: add the shared chroma offsets to a luma value and clamp.
`default_nettype none

module ycc_lane
	import ycc_pkg::*;
(
	input  wire logic [LUMA_W-1:0]       luma,
	input  wire logic signed [OFF_W-1:0] red_off,
	input  wire logic signed [OFF_W-1:0] green_off,
	input  wire logic signed [OFF_W-1:0] blue_off,
	output ycc_pixel_t                   pix
);

	localparam int SUM_W = OFF_W + 1;

	function automatic logic [LUMA_W-1:0] sat(input logic [LUMA_W-1:0] y,
		input logic signed [OFF_W-1:0] off);
		logic signed [SUM_W-1:0] s;
		s = signed'({2'b00, y}) + SUM_W'(off);
		if (s[SUM_W-1])
			return '0;
		else if (s[SUM_W-2])
			return '1;
		else
			return s[LUMA_W-1:0];
	endfunction

	always_comb begin
		pix.red   = sat(luma, red_off);
		pix.green = sat(luma, green_off);
		pix.blue  = sat(luma, blue_off);
	end

endmodule

`default_nettype wire

>>> rtl/ycbcr411_group_to_rgb.sv
// Top level: YCbCr 4:1:1 group to four RGB pixels, four pixel lanes.
//
// Input channel "group": luma0..luma3, blue_chroma and red_chroma, qualified
// by group_valid; the block holds group_stall high while it cannot take one.
// Output channel "pixel": red/green/blue for pixels 0..3, qualified by
// pixel_valid; the receiver holds pixel_stall high to refuse a transfer.
// Pipeline: a group taken at one clock edge passes through four registers to
// the outputs, the first loaded at the accepting edge (chroma numerators,
// reciprocal multiply, remainder correction, lane add and clamp into the
// output register).
// Throughput: one group per cycle while pixel_stall is low; the chroma
// offsets are computed once and shared by the four pixel lanes.
// A stalled result stays in the output register with its payload frozen.
// Each stage loads while it is empty or its content moves on, so bubbles
// fill up during a stall; group_stall rises once all four stages are full.
// Reset clears all valid flags: the pipeline comes up empty, pixel_valid is
// low and the block takes a group in the first cycle after reset.
`default_nettype none

module ycbcr411_group_to_rgb
	import ycc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                group_valid,
	output logic                     group_stall,
	input  wire logic [LUMA_W-1:0]   luma0,
	input  wire logic [LUMA_W-1:0]   luma1,
	input  wire logic [CHROMA_W-1:0] blue_chroma,
	input  wire logic [LUMA_W-1:0]   luma2,
	input  wire logic [LUMA_W-1:0]   luma3,
	input  wire logic [CHROMA_W-1:0] red_chroma,
	output logic                     pixel_valid,
	input  wire logic                pixel_stall,
	output logic [LUMA_W-1:0]        red0,
	output logic [LUMA_W-1:0]        green0,
	output logic [LUMA_W-1:0]        blue0,
	output logic [LUMA_W-1:0]        red1,
	output logic [LUMA_W-1:0]        green1,
	output logic [LUMA_W-1:0]        blue1,
	output logic [LUMA_W-1:0]        red2,
	output logic [LUMA_W-1:0]        green2,
	output logic [LUMA_W-1:0]        blue2,
	output logic [LUMA_W-1:0]        red3,
	output logic [LUMA_W-1:0]        green3,
	output logic [LUMA_W-1:0]        blue3
);

	logic v1_q, v2_q, v3_q, vo_q;
	logic rdy1, rdy2, rdy3, rdy_o;
	ycc_adv_t adv;

	logic signed [CHROMA_W-1:0] cb;
	logic signed [CHROMA_W-1:0] cr;
	logic signed [RB_NUM_W-1:0] cb_rb;
	logic signed [RB_NUM_W-1:0] cr_rb;
	logic signed [G_NUM_W-1:0]  cb_g;
	logic signed [G_NUM_W-1:0]  cr_g;

	logic signed [RB_NUM_W-1:0] rnum_s1;
	logic signed [RB_NUM_W-1:0] bnum_s1;
	logic signed [G_NUM_W-1:0]  gnum_s1;

	logic [LANES-1:0][LUMA_W-1:0] luma_s1;
	logic [LANES-1:0][LUMA_W-1:0] luma_s2;
	logic [LANES-1:0][LUMA_W-1:0] luma_s3;

	logic signed [OFF_W-1:0] red_off;
	logic signed [OFF_W-1:0] green_off;
	logic signed [OFF_W-1:0] blue_off;

	ycc_pixel_t pix [LANES];
	ycc_pixel_t pix_q [LANES];

	always_comb begin
		rdy_o       = !vo_q || !pixel_stall;
		rdy3        = !v3_q || rdy_o;
		rdy2        = !v2_q || rdy3;
		rdy1        = !v1_q || rdy2;
		group_stall = !rdy1;
		adv.s2      = rdy2;
		adv.s3      = rdy3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= group_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy_o)
				vo_q <= v3_q;
		end
	end

	// center chroma: flip the top bit to remove the bias of 128
	always_comb begin
		cb    = signed'({~blue_chroma[CHROMA_W-1], blue_chroma[CHROMA_W-2:0]});
		cr    = signed'({~red_chroma[CHROMA_W-1], red_chroma[CHROMA_W-2:0]});
		cb_rb = RB_NUM_W'(cb);
		cr_rb = RB_NUM_W'(cr);
		cb_g  = G_NUM_W'(cb);
		cr_g  = G_NUM_W'(cr);
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			rnum_s1 <= cr_rb * RB_NUM_W'(RED_COEF) + RB_NUM_W'(RB_HALF);
			bnum_s1 <= cb_rb * RB_NUM_W'(BLUE_COEF) + RB_NUM_W'(RB_HALF);
			gnum_s1 <= G_NUM_W'(G_HALF) - cb_g * G_NUM_W'(G_CB_COEF)
				- cr_g * G_NUM_W'(G_CR_COEF);
			luma_s1 <= {luma3, luma2, luma1, luma0};
		end
		if (rdy2)
			luma_s2 <= luma_s1;
		if (rdy3)
			luma_s3 <= luma_s2;
	end

	ycc_cdiv #(
		.NUM_W  (RB_NUM_W),
		.QUO_W  (OFF_W),
		.DIVISOR(RB_DIV),
		.SHIFT  (RB_SHIFT),
		.RECIP  (RB_RECIP)
	) u_red_div (
		.clk(clk),
		.adv(adv),
		.num(rnum_s1),
		.quo(red_off)
	);

	ycc_cdiv #(
		.NUM_W  (G_NUM_W),
		.QUO_W  (OFF_W),
		.DIVISOR(G_DIV),
		.SHIFT  (G_SHIFT),
		.RECIP  (G_RECIP)
	) u_green_div (
		.clk(clk),
		.adv(adv),
		.num(gnum_s1),
		.quo(green_off)
	);

	ycc_cdiv #(
		.NUM_W  (RB_NUM_W),
		.QUO_W  (OFF_W),
		.DIVISOR(RB_DIV),
		.SHIFT  (RB_SHIFT),
		.RECIP  (RB_RECIP)
	) u_blue_div (
		.clk(clk),
		.adv(adv),
		.num(bnum_s1),
		.quo(blue_off)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		ycc_lane u_lane (
			.luma     (luma_s3[k]),
			.red_off  (red_off),
			.green_off(green_off),
			.blue_off (blue_off),
			.pix      (pix[k])
		);

		always_ff @(posedge clk) begin
			if (rdy_o)
				pix_q[k] <= pix[k];
		end
	end

	always_comb begin
		pixel_valid = vo_q;
		red0   = pix_q[0].red;
		green0 = pix_q[0].green;
		blue0  = pix_q[0].blue;
		red1   = pix_q[1].red;
		green1 = pix_q[1].green;
		blue1  = pix_q[1].blue;
		red2   = pix_q[2].red;
		green2 = pix_q[2].green;
		blue2  = pix_q[2].blue;
		red3   = pix_q[3].red;
		green3 = pix_q[3].green;
		blue3  = pix_q[3].blue;
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid && !group_stall |=> v1_q)
		else $error("accepted group did not enter the first stage");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && v2_q && v3_q && pixel_valid && pixel_stall |-> group_stall)
		else $error("group taken while every stage is full and stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && !v3_q |=> !pixel_valid)
		else $error("result repeated after transfer");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && !rdy_o |=> v3_q)
		else $error("result dropped in front of stalled output");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for ycbcr411_group_to_rgb: directed and random pixel groups against a predictor.
module tb_top
	import ycc_pkg::*;
();

	typedef struct packed {
		logic [LUMA_W-1:0]   luma0;
		logic [LUMA_W-1:0]   luma1;
		logic [CHROMA_W-1:0] cb;
		logic [LUMA_W-1:0]   luma2;
		logic [LUMA_W-1:0]   luma3;
		logic [CHROMA_W-1:0] cr;
	} group_t;

	typedef ycc_pixel_t [0:LANES-1] rgb_quad_t;

	typedef struct packed {
		bit        typed;
		group_t    grp;
		rgb_quad_t rgb;
	} vector_t;

	localparam int CHROMA_ZERO   = 128;
	localparam int PIXEL_MAX     = 255;
	localparam int RANDOM_GROUPS = 836;
	localparam int HOLD_AT       = 200;
	localparam int LONG_HOLD     = 64;
	localparam int STEADY_FROM   = 450;
	localparam int FREE_FROM     = 500;
	localparam int FREE_TO       = 650;
	localparam int DRAIN_CYCLES  = 8;
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_MAX    = 10;
	localparam rgb_quad_t PREDICT = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              group_valid;
	logic              group_stall;
	logic [LUMA_W-1:0] luma0, luma1, luma2, luma3;
	logic [LUMA_W-1:0] blue_chroma, red_chroma;
	logic              pixel_valid;
	logic              pixel_stall;
	logic [LUMA_W-1:0] red0, green0, blue0, red1, green1, blue1;
	logic [LUMA_W-1:0] red2, green2, blue2, red3, green3, blue3;

	rgb_quad_t expected_rgb [$];
	int        groups_sent   = 0;
	int        quads_checked = 0;
	int        mismatches    = 0;
	int        burst_left    = 0;
	int        idle_cycles   = 0;
	int        hold_cycles   = 0;

	// l0, l1, Cb, l2, l3, Cr, then four {r, g, b} pixels where typed in
	vector_t directed_table [$] = '{
		{1'b1, {8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd128},
			{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
			 8'd1, 8'd1, 8'd1, 8'd254, 8'd254, 8'd254}},
		{1'b1, {8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd0},
			{8'd77, 8'd255, 8'd29, 8'd0, 8'd135, 8'd0,
			 8'd77, 8'd255, 8'd29, 8'd0, 8'd255, 8'd0}},
		{1'b1, {8'd0, 8'd255, 8'd255, 8'd128, 8'd50, 8'd255},
			{8'd178, 8'd0, 8'd225, 8'd255, 8'd122, 8'd255,
			 8'd255, 8'd0, 8'd255, 8'd228, 8'd0, 8'd255}},
		{1'b0, {8'd16, 8'd235, 8'd0, 8'd128, 8'd64, 8'd255}, PREDICT},
		{1'b0, {8'd16, 8'd235, 8'd255, 8'd128, 8'd64, 8'd0}, PREDICT},
		{1'b0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, PREDICT},
		{1'b0, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, PREDICT},
		{1'b0, {8'd128, 8'd128, 8'd127, 8'd128, 8'd128, 8'd129}, PREDICT},
		{1'b0, {8'd128, 8'd128, 8'd129, 8'd128, 8'd128, 8'd127}, PREDICT},
		{1'b0, {8'd1, 8'd254, 8'd1, 8'd200, 8'd100, 8'd254}, PREDICT},
		{1'b0, {8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55}, PREDICT},
		{1'b0, {8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa}, PREDICT},
		{1'b0, {8'd200, 8'd30, 8'd64, 8'd90, 8'd170, 8'd192}, PREDICT},
		{1'b0, {8'd100, 8'd100, 8'd192, 8'd100, 8'd100, 8'd64}, PREDICT},
		{1'b0, {8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0}, PREDICT},
		{1'b0, {8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd128}, PREDICT}
	};

	ycbcr411_group_to_rgb i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.group_valid (group_valid),
		.group_stall (group_stall),
		.luma0       (luma0),
		.luma1       (luma1),
		.blue_chroma (blue_chroma),
		.luma2       (luma2),
		.luma3       (luma3),
		.red_chroma  (red_chroma),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red0        (red0),
		.green0      (green0),
		.blue0       (blue0),
		.red1        (red1),
		.green1      (green1),
		.blue1       (blue1),
		.red2        (red2),
		.green2      (green2),
		.blue2       (blue2),
		.red3        (red3),
		.green3      (green3),
		.blue3       (blue3)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LUMA_W-1:0] clamp_byte(int v);
		if (v < 0)
			return '0;
		if (v > PIXEL_MAX)
			return LUMA_W'(PIXEL_MAX);
		return LUMA_W'(v);
	endfunction

	function automatic rgb_quad_t convert_group(group_t g);
		int        cb, cr, red_off, green_off, blue_off;
		int        luma [LANES];
		rgb_quad_t rgb;
		cb = int'(g.cb) - CHROMA_ZERO;
		cr = int'(g.cr) - CHROMA_ZERO;
		red_off   = (RED_COEF * cr + RB_HALF) / RB_DIV;
		green_off = (-G_CB_COEF * cb - G_CR_COEF * cr + G_HALF) / G_DIV;
		blue_off  = (BLUE_COEF * cb + RB_HALF) / RB_DIV;
		luma = '{int'(g.luma0), int'(g.luma1), int'(g.luma2), int'(g.luma3)};
		for (int k = 0; k < LANES; k++) begin
			rgb[k].red   = clamp_byte(luma[k] + red_off);
			rgb[k].green = clamp_byte(luma[k] + green_off);
			rgb[k].blue  = clamp_byte(luma[k] + blue_off);
		end
		return rgb;
	endfunction

	function automatic logic [LUMA_W-1:0] corner_byte();
		logic [LUMA_W-1:0] corners [7] =
			'{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
		return corners[$urandom_range(0, 6)];
	endfunction

	function automatic group_t random_group();
		logic [63:0] bits;
		group_t      g;
		int          mode;
		bits = {$urandom, $urandom};
		g = bits[$bits(group_t)-1:0];
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			g.cb = corner_byte();
			g.cr = corner_byte();
		end else if (mode == 2) begin
			g.luma0 = corner_byte();
			g.luma1 = corner_byte();
			g.luma2 = corner_byte();
			g.luma3 = corner_byte();
		end
		return g;
	endfunction

	task automatic offer_group(group_t g, rgb_quad_t want);
		int gap;
		if (burst_left == 0) begin
			gap = (groups_sent >= STEADY_FROM && groups_sent < FREE_TO) ?
				0 : $urandom_range(0, 6);
			if (gap > 0) begin
				group_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		group_valid <= 1'b1;
		luma0       <= g.luma0;
		luma1       <= g.luma1;
		blue_chroma <= g.cb;
		luma2       <= g.luma2;
		luma3       <= g.luma3;
		red_chroma  <= g.cr;
		@(posedge clk);
		while (group_stall)
			@(posedge clk);
		expected_rgb.push_back(want);
		groups_sent++;
		burst_left--;
	endtask

	task automatic report_mismatch(string channel, int lane, logic [LUMA_W-1:0] want,
			logic [LUMA_W-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: quad %0d %s%0d expected %0d got %0d",
				$time, quads_checked, channel, lane, want, got);
	endtask

	initial begin : source_groups
		group_t g;
		arst_n      <= 1'b0;
		group_valid <= 1'b0;
		luma0       <= '0;
		luma1       <= '0;
		blue_chroma <= '0;
		luma2       <= '0;
		luma3       <= '0;
		red_chroma  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_table[i])
			offer_group(directed_table[i].grp, directed_table[i].typed ?
				directed_table[i].rgb : convert_group(directed_table[i].grp));
		repeat (RANDOM_GROUPS) begin
			g = random_group();
			offer_group(g, convert_group(g));
		end
		group_valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d groups sent (%0d directed), %0d pixel quads checked, %0d mismatches",
			groups_sent, directed_table.size(), quads_checked, mismatches);
		$display("output held off for %0d cycles in one stretch, with bursty input throughout",
			hold_cycles);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin : sink_pixels
		int  hold, run;
		bit  held;
		held = 1'b0;
		pixel_stall <= 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			if (!held && groups_sent >= HOLD_AT) begin
				held = 1'b1;
				pixel_stall <= 1'b1;
				for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
					@(posedge clk);
			end else if (groups_sent >= FREE_FROM && groups_sent < FREE_TO) begin
				pixel_stall <= 1'b0;
				@(posedge clk);
			end else begin
				hold = $urandom_range(1, 5);
				run  = $urandom_range(1, 10);
				pixel_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				pixel_stall <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_pixels
		rgb_quad_t got, want;
		if (arst_n && pixel_valid && !pixel_stall) begin
			got = {red0, green0, blue0, red1, green1, blue1,
				red2, green2, blue2, red3, green3, blue3};
			if (expected_rgb.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: pixel transfer with no group pending", $time);
			end else begin
				want = expected_rgb.pop_front();
				for (int k = 0; k < LANES; k++) begin
					if (got[k].red !== want[k].red)
						report_mismatch("red", k, want[k].red, got[k].red);
					if (got[k].green !== want[k].green)
						report_mismatch("green", k, want[k].green, got[k].green);
					if (got[k].blue !== want[k].blue)
						report_mismatch("blue", k, want[k].blue, got[k].blue);
				end
				quads_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((group_valid && !group_stall) || (pixel_valid && !pixel_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles with no transfer, %0d quads pending",
				idle_cycles, expected_rgb.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

endmodule
